// ===== sv/utf8_stream_decoder_defines.svh =====
// ----------------------------------------------------------------------------
// UTF-8 stream decoder assertion macros
// Shared property shorthands for the decoder's checks.
// ----------------------------------------------------------------------------
`ifndef UTF8_STREAM_DECODER_DEFINES_SVH
`define UTF8_STREAM_DECODER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define UTF8D_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define UTF8D_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/utf8d_pkg.sv =====
// ----------------------------------------------------------------------------
// UTF-8 stream decoder package
// Request types, decode step result and byte window control shared by modules.
// ----------------------------------------------------------------------------
`default_nettype none

package utf8d_pkg;

  // replacement character for every error
  localparam logic [20:0] REPL_CP = 21'h00FFFD;

  // input request
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_string;
  } in_t;

  // output request
  typedef struct packed {
    logic [20:0] code_point;
    logic [2:0]  bytes_used;
    logic        is_invalid;
    logic        is_truncated;
    logic        last_of_run;
  } out_t;

  // four-byte decode window, entry 0 is the front
  typedef logic [3:0][7:0] win_t;

  typedef enum logic [1:0] {
    DEC_OK,
    DEC_BAD,
    DEC_SHORT
  } dec_status_e;

  // outcome of one decode step on the window front
  typedef struct packed {
    dec_status_e status;
    logic [20:0] cp;
    logic [2:0]  len;
  } dec_res_t;

  // byte window control from the sequencer
  typedef struct packed {
    logic       load;
    logic       shift;
    logic [2:0] shift_len;
  } buf_ctrl_t;

endpackage

`default_nettype wire

// ===== sv/utf8d_buf.sv =====
// ----------------------------------------------------------------------------
// UTF-8 decoder byte window
// Holds up to four bytes; appends a new byte and drops consumed front bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8d_buf (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire utf8d_pkg::buf_ctrl_t ctrl_i,
  input  wire logic [7:0]           byte_i,
  output utf8d_pkg::win_t           window_o,
  output logic [2:0]                count_o
);

  utf8d_pkg::win_t bytes_q, bytes_d;
  logic [2:0]      count_q, count_d;

  // append at the fill point, or shift the window down
  always_comb begin
    logic [2:0] idx;
    idx     = '0;
    bytes_d = bytes_q;
    count_d = count_q;
    if (ctrl_i.load) begin
      bytes_d[count_q[1:0]] = byte_i;
      count_d               = count_q + 3'd1;
    end else if (ctrl_i.shift) begin
      for (int i = 0; i < 4; i++) begin
        idx = 3'(i) + ctrl_i.shift_len;
        if (idx < 3'd4) begin
          bytes_d[i] = bytes_q[idx[1:0]];
        end
      end
      count_d = count_q - ctrl_i.shift_len;
    end
  end

  // byte storage, no reset needed
  always_ff @(posedge clk_i) begin
    bytes_q <= bytes_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  assign window_o = bytes_q;
  assign count_o  = count_q;

endmodule

`default_nettype wire

// ===== sv/utf8d_dec.sv =====
// ----------------------------------------------------------------------------
// UTF-8 decoder step unit
// Decodes one sequence at the window front: valid, malformed or too short.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8d_dec (
  input  wire utf8d_pkg::win_t     window_i,
  input  wire logic [2:0]          count_i,
  output utf8d_pkg::dec_res_t      res_o
);

  always_comb begin
    logic [7:0]  c0, b1, b2, b3;
    logic [10:0] r2;
    logic [15:0] r3;
    logic [20:0] r4;
    c0 = window_i[0];
    b1 = window_i[1];
    b2 = window_i[2];
    b3 = window_i[3];
    r2 = {c0[4:0], b1[5:0]};
    r3 = {c0[3:0], b1[5:0], b2[5:0]};
    r4 = {c0[2:0], b1[5:0], b2[5:0], b3[5:0]};

    res_o.status = utf8d_pkg::DEC_BAD;
    res_o.cp     = utf8d_pkg::REPL_CP;
    res_o.len    = 3'd1;

    if (c0 < 8'h80) begin
      // plain ASCII
      res_o.status = utf8d_pkg::DEC_OK;
      res_o.cp     = 21'(c0);
    end else if (c0 < 8'hC0 || c0 >= 8'hF8) begin
      // stray continuation or illegal lead
      res_o.status = utf8d_pkg::DEC_BAD;
    end else if (count_i < 3'd2) begin
      res_o.status = utf8d_pkg::DEC_SHORT;
    end else if (b1[7:6] != 2'b10) begin
      res_o.status = utf8d_pkg::DEC_BAD;
    end else if (c0 < 8'hE0) begin
      // two-byte form, reject overlong
      if (r2 > 11'h07F) begin
        res_o.status = utf8d_pkg::DEC_OK;
        res_o.cp     = 21'(r2);
        res_o.len    = 3'd2;
      end
    end else if (count_i < 3'd3) begin
      res_o.status = utf8d_pkg::DEC_SHORT;
    end else if (b2[7:6] != 2'b10) begin
      res_o.status = utf8d_pkg::DEC_BAD;
    end else if (c0 < 8'hF0) begin
      // three-byte form, reject overlong and surrogates
      if (r3 > 16'h07FF && !(r3 >= 16'hD800 && r3 <= 16'hDFFF)) begin
        res_o.status = utf8d_pkg::DEC_OK;
        res_o.cp     = 21'(r3);
        res_o.len    = 3'd3;
      end
    end else if (count_i < 3'd4) begin
      res_o.status = utf8d_pkg::DEC_SHORT;
    end else if (b3[7:6] != 2'b10) begin
      res_o.status = utf8d_pkg::DEC_BAD;
    end else if (r4 > 21'h00FFFF && r4 <= 21'h10FFFF) begin
      // four-byte form within range
      res_o.status = utf8d_pkg::DEC_OK;
      res_o.cp     = r4;
      res_o.len    = 3'd4;
    end
  end

endmodule

`default_nettype wire

// ===== sv/utf8_stream_decoder.sv =====
// ----------------------------------------------------------------------------
// UTF-8 stream decoder
// Byte-in, code-point-out decoder with error replacement and replay.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid_i / in_stall_o / in_data_i takes one byte per
//   request plus an end-of-string flag. Output channel out_valid_o /
//   out_stall_i / out_data_o gives code points with their byte count and
//   error flags; last_of_run marks the final result caused by a byte.
//   A byte that completes or breaks a sequence yields 1 to 4 results; a byte
//   that leaves a sequence open yields none.
//   Timing: one decode step per cycle while the output is not stalled, through
//   a single shared step unit. Each result of a byte passes through the hold
//   register and then the output register. in_stall_o is high while the
//   sequencer works on a byte. Reset empties the pending byte window and the
//   output register. A stalled output holds its result; the sequencer waits
//   on it while it has a further result ready to pass on.
// ----------------------------------------------------------------------------
`default_nettype none

`include "utf8_stream_decoder_defines.svh"

module utf8_stream_decoder (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  input  wire utf8d_pkg::in_t  in_data_i,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output utf8d_pkg::out_t      out_data_o
);

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_e;

  state_e               state_q, state_d;
  logic                 eos_q, eos_d;
  logic                 hold_valid_q, hold_valid_d;
  utf8d_pkg::out_t      hold_q, hold_d;
  logic                 out_valid_q, out_valid_d;
  utf8d_pkg::out_t      out_q, out_d;

  utf8d_pkg::buf_ctrl_t buf_ctrl;
  utf8d_pkg::win_t      window;
  logic [2:0]           count;
  utf8d_pkg::dec_res_t  dec_res;
  utf8d_pkg::out_t      step_res;
  logic                 out_free;
  logic                 push;
  utf8d_pkg::out_t      push_data;

  utf8d_buf u_buf (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (buf_ctrl),
    .byte_i   (in_data_i.data_byte),
    .window_o (window),
    .count_o  (count)
  );

  utf8d_dec u_dec (
    .window_i (window),
    .count_i  (count),
    .res_o    (dec_res)
  );

  // result of the current decode step
  always_comb begin
    step_res.code_point   = utf8d_pkg::REPL_CP;
    step_res.bytes_used   = 3'd1;
    step_res.is_invalid   = 1'b0;
    step_res.is_truncated = 1'b0;
    step_res.last_of_run  = 1'b0;
    case (dec_res.status)
      utf8d_pkg::DEC_OK: begin
        step_res.code_point = dec_res.cp;
        step_res.bytes_used = dec_res.len;
      end
      utf8d_pkg::DEC_BAD: begin
        step_res.is_invalid = 1'b1;
      end
      default: begin
        step_res.is_truncated = 1'b1;
      end
    endcase
  end

  assign out_free = !out_valid_q || !out_stall_i;

  // sequencer: one decode per cycle while the output can take a result, the
  // previous result is held until it is known whether it ends the run
  always_comb begin
    state_d      = state_q;
    eos_d        = eos_q;
    hold_valid_d = hold_valid_q;
    hold_d       = hold_q;
    buf_ctrl     = '0;
    push         = 1'b0;
    push_data    = hold_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          buf_ctrl.load = 1'b1;
          eos_d         = in_data_i.end_of_string;
          state_d       = ST_RUN;
        end
      end
      ST_RUN: begin
        if (count == 3'd0) begin
          // window drained: held result closes the run
          if (out_free) begin
            push                  = 1'b1;
            push_data.last_of_run = 1'b1;
            hold_valid_d          = 1'b0;
            state_d               = ST_IDLE;
          end
        end else if (dec_res.status == utf8d_pkg::DEC_SHORT && !eos_q) begin
          // open sequence stays pending
          if (!hold_valid_q) begin
            state_d = ST_IDLE;
          end else if (out_free) begin
            push                  = 1'b1;
            push_data.last_of_run = 1'b1;
            hold_valid_d          = 1'b0;
            state_d               = ST_IDLE;
          end
        end else if (!hold_valid_q || out_free) begin
          // emit: pass on the held result, keep the new one
          push               = hold_valid_q;
          hold_d             = step_res;
          hold_valid_d       = 1'b1;
          buf_ctrl.shift     = 1'b1;
          buf_ctrl.shift_len = step_res.bytes_used;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (push) begin
      out_valid_d = 1'b1;
      out_d       = push_data;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      eos_q        <= 1'b0;
      hold_valid_q <= 1'b0;
      hold_q       <= '0;
      out_valid_q  <= 1'b0;
      out_q        <= '0;
    end else begin
      state_q      <= state_d;
      eos_q        <= eos_d;
      hold_valid_q <= hold_valid_d;
      hold_q       <= hold_d;
      out_valid_q  <= out_valid_d;
      out_q        <= out_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // checks
  `UTF8D_ASSERT_IMP(a_idle_no_hold, clk_i, rst_ni, state_q == ST_IDLE, !hold_valid_q, "held result left over in idle")
  `UTF8D_ASSERT_NXT(a_accept_busy, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o, "not busy after accepting a byte")
  `UTF8D_ASSERT_IMP(a_err_repl, clk_i, rst_ni, out_valid_o && (out_q.is_invalid || out_q.is_truncated), out_q.code_point == utf8d_pkg::REPL_CP && out_q.bytes_used == 3'd1 && !(out_q.is_invalid && out_q.is_truncated), "malformed error result")
  `UTF8D_ASSERT_IMP(a_out_range, clk_i, rst_ni, out_valid_o, out_q.code_point <= 21'h10FFFF && out_q.bytes_used != 3'd0 && out_q.bytes_used <= 3'd4, "result out of range")

endmodule

`default_nettype wire

// ===== verif/tb_utf8_stream_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 stream decoder testbench
// Feeds byte streams through the decoder and compares every code point
// result, field by field, against an in-bench decoder of the same bytes.
// Covers well-formed text, rejected forms, end-of-string truncation, random
// sender gaps and receiver stalls, and a long output hold-off.
// ----------------------------------------------------------------------------
module tb_utf8_stream_decoder;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned HOLD_CYCLES = 160;
  localparam int unsigned SETTLE_CYCLES = 8;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            in_valid_i = 1'b0;
  logic            in_stall_o;
  utf8d_pkg::in_t  in_data_i = '0;
  logic            out_valid_o;
  logic            out_stall_i = 1'b0;
  utf8d_pkg::out_t out_data_o;

  // decoder copy: bytes of an unfinished sequence
  logic [7:0]      carry_bytes [3];
  int unsigned     carry_cnt = 0;
  utf8d_pkg::out_t expected_cps [$];

  logic [7:0]  seq_bytes [$];
  int unsigned bytes_fed = 0;
  int unsigned mismatches = 0;
  int unsigned cycle_cnt = 0;

  // idling controls
  logic        tx_gaps_on = 1'b1;
  logic        rx_stall_on = 1'b1;
  int unsigned hold_trigger = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  int unsigned burst_left = 0;

  utf8_stream_decoder DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always #10 clk_i = ~clk_i;

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // ------------------------------------------------------------------
  // Decoder copy
  // ------------------------------------------------------------------

  function automatic logic is_trail(input logic [7:0] c);
    return c[7:6] == 2'b10;
  endfunction

  // decode one sequence from the front of the byte window at pos
  function automatic utf8d_pkg::dec_status_e scan_seq(input utf8d_pkg::win_t w,
                                                      input int unsigned pos,
                                                      input int unsigned avail,
                                                      output logic [20:0] cp,
                                                      output int unsigned len);
    logic [7:0]  c0;
    logic [20:0] r;
    c0 = w[pos];
    cp = '0;
    len = 0;
    if (c0 < 8'h80) begin
      cp = {13'd0, c0};
      len = 1;
      return utf8d_pkg::DEC_OK;
    end
    if (c0 < 8'hC0 || c0 >= 8'hF8) return utf8d_pkg::DEC_BAD;
    if (avail < 2) return utf8d_pkg::DEC_SHORT;
    if (!is_trail(w[pos+1])) return utf8d_pkg::DEC_BAD;
    if (c0 < 8'hE0) begin
      r = {10'd0, c0[4:0], w[pos+1][5:0]};
      if (r <= 21'h7F) return utf8d_pkg::DEC_BAD;
      cp = r;
      len = 2;
      return utf8d_pkg::DEC_OK;
    end
    if (avail < 3) return utf8d_pkg::DEC_SHORT;
    if (!is_trail(w[pos+2])) return utf8d_pkg::DEC_BAD;
    if (c0 < 8'hF0) begin
      r = {5'd0, c0[3:0], w[pos+1][5:0], w[pos+2][5:0]};
      if (r <= 21'h7FF) return utf8d_pkg::DEC_BAD;
      if (r >= 21'hD800 && r <= 21'hDFFF) return utf8d_pkg::DEC_BAD;
      cp = r;
      len = 3;
      return utf8d_pkg::DEC_OK;
    end
    if (avail < 4) return utf8d_pkg::DEC_SHORT;
    if (!is_trail(w[pos+3])) return utf8d_pkg::DEC_BAD;
    r = {c0[2:0], w[pos+1][5:0], w[pos+2][5:0], w[pos+3][5:0]};
    if (r <= 21'hFFFF || r > 21'h10FFFF) return utf8d_pkg::DEC_BAD;
    cp = r;
    len = 4;
    return utf8d_pkg::DEC_OK;
  endfunction

  // join carried bytes with the new byte, queue every result it causes
  task automatic decode_step(input logic [7:0] b, input logic eos);
    utf8d_pkg::win_t        win;
    utf8d_pkg::out_t        res [4];
    int unsigned            total, pos, nres, len, i;
    logic [20:0]            cp;
    utf8d_pkg::dec_status_e st;
    win = '0;
    for (i = 0; i < carry_cnt; i++) win[i] = carry_bytes[i];
    win[carry_cnt] = b;
    total = carry_cnt + 1;
    pos = 0;
    nres = 0;
    while (pos < total && nres < 4) begin
      st = scan_seq(win, pos, total - pos, cp, len);
      if (st == utf8d_pkg::DEC_OK) begin
        res[nres] = '{cp, len[2:0], 1'b0, 1'b0, 1'b0};
      end else if (st == utf8d_pkg::DEC_BAD || eos) begin
        // errors consume one byte; the rest is decoded again
        res[nres] = '{utf8d_pkg::REPL_CP, 3'd1, (st == utf8d_pkg::DEC_BAD),
                      (st != utf8d_pkg::DEC_BAD), 1'b0};
        len = 1;
      end else begin
        break;
      end
      nres++;
      pos += len;
    end
    carry_cnt = total - pos;
    for (i = 0; i < carry_cnt; i++) carry_bytes[i] = win[pos+i];
    if (nres > 0) res[nres-1].last_of_run = 1'b1;
    for (i = 0; i < nres; i++) expected_cps.push_back(res[i]);
  endtask

  // ------------------------------------------------------------------
  // Result checking
  // ------------------------------------------------------------------

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  initial begin
    logic            out_fire;
    utf8d_pkg::out_t got, want;
    forever begin
      @(negedge clk_i);
      out_fire = out_valid_o && !out_stall_i;
      got = out_data_o;
      @(posedge clk_i);
      if (out_fire) begin
        if (expected_cps.size() == 0) begin
          $error("unexpected result: code_point 0x%0h", got.code_point);
          mismatches++;
        end else begin
          want = expected_cps.pop_front();
          check_field("code_point", 32'(want.code_point), 32'(got.code_point));
          check_field("bytes_used", 32'(want.bytes_used), 32'(got.bytes_used));
          check_field("is_invalid", 32'(want.is_invalid), 32'(got.is_invalid));
          check_field("is_truncated", 32'(want.is_truncated), 32'(got.is_truncated));
          check_field("last_of_run", 32'(want.last_of_run), 32'(got.last_of_run));
        end
      end
    end
  end

  // receiver stall: random bursts, plus a long hold when the test asks
  always @(posedge clk_i) begin
    if (hold_trigger != hold_seen) begin
      hold_seen = hold_trigger;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (burst_left != 0) begin
      burst_left--;
      out_stall_i <= 1'b1;
    end else if (rx_stall_on && $urandom_range(0, 5) == 0) begin
      burst_left = $urandom_range(0, 3);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // ------------------------------------------------------------------
  // Stimulus
  // ------------------------------------------------------------------

  // offer one byte request; valid stays high after acceptance
  task automatic send_byte(input logic [7:0] b, input logic eos);
    utf8d_pkg::in_t req;
    logic           took;
    if (tx_gaps_on && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    req.data_byte = b;
    req.end_of_string = eos;
    in_valid_i <= 1'b1;
    in_data_i <= req;
    do begin
      @(negedge clk_i);
      took = !in_stall_o;
      @(posedge clk_i);
    end while (!took);
    decode_step(b, eos);
    bytes_fed++;
  endtask

  // drop valid and wait until every expected result is out
  task automatic finish_phase();
    in_valid_i <= 1'b0;
    while (expected_cps.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // encode cp in exactly n bytes (overlong when n is more than needed)
  task automatic build_seq(input logic [20:0] cp, input int unsigned n);
    seq_bytes.delete();
    case (n)
      1: seq_bytes.push_back({1'b0, cp[6:0]});
      2: begin
        seq_bytes.push_back({3'b110, cp[10:6]});
        seq_bytes.push_back({2'b10, cp[5:0]});
      end
      3: begin
        seq_bytes.push_back({4'b1110, cp[15:12]});
        seq_bytes.push_back({2'b10, cp[11:6]});
        seq_bytes.push_back({2'b10, cp[5:0]});
      end
      default: begin
        seq_bytes.push_back({5'b11110, cp[20:18]});
        seq_bytes.push_back({2'b10, cp[17:12]});
        seq_bytes.push_back({2'b10, cp[11:6]});
        seq_bytes.push_back({2'b10, cp[5:0]});
      end
    endcase
  endtask

  // a range end of each sequence length
  task automatic test_valid_forms();
    send_byte(8'h00, 1'b0);
    send_byte(8'hC2, 1'b0);   // U+0080
    send_byte(8'h80, 1'b0);
    send_byte(8'hEF, 1'b0);   // U+FFFF
    send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hF4, 1'b0);   // U+10FFFF
    send_byte(8'h8F, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b1);
    finish_phase();
  endtask

  // rejected forms, several with multi-result replays
  task automatic test_rejected_forms();
    send_byte(8'hED, 1'b0);   // surrogate U+D800
    send_byte(8'hA0, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hF4, 1'b0);   // above U+10FFFF
    send_byte(8'h90, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hC0, 1'b0);   // overlong two-byte
    send_byte(8'hAF, 1'b0);
    send_byte(8'hFF, 1'b0);   // lead byte never valid
    send_byte(8'hC2, 1'b0);   // bad continuation
    send_byte(8'h41, 1'b0);
    send_byte(8'hF0, 1'b0);   // bad fourth byte, ASCII replays out
    send_byte(8'h90, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h7F, 1'b1);
    finish_phase();
  endtask

  // string ends inside an open sequence
  task automatic test_truncation();
    send_byte(8'hE2, 1'b0);
    send_byte(8'h82, 1'b1);
    finish_phase();
  endtask

  // mostly well-formed text with random content, some broken sequences
  task automatic test_random_text(input int unsigned n_bytes);
    int unsigned start, kind, len, keep, pos;
    logic [20:0] cp;
    logic        eos;
    start = bytes_fed;
    while (bytes_fed - start < n_bytes) begin
      kind = $urandom_range(0, 99);
      len = $urandom_range(1, 4);
      case (len)
        1: cp = 21'($urandom_range(0, 'h7F));
        2: cp = 21'($urandom_range('h80, 'h7FF));
        3: cp = 21'($urandom_range('h800, 'hFFFF));
        default: cp = 21'($urandom_range('h10000, 'h10FFFF));
      endcase
      if (kind >= 70 && kind < 78) begin
        // overlong or beyond the code space
        len = $urandom_range(2, 4);
        if (len == 4 && $urandom_range(0, 1) == 1)
          cp = 21'($urandom_range('h110000, 'h1FFFFF));
        else
          cp = 21'($urandom_range(0, len == 2 ? 'h7F : (len == 3 ? 'h7FF : 'hFFFF)));
      end
      build_seq(cp, len);
      keep = len;
      if (kind >= 78 && kind < 88 && len > 1) begin
        keep = $urandom_range(1, len - 1);   // cut short
      end else if (kind >= 88 && kind < 94 && len > 1) begin
        seq_bytes[$urandom_range(1, len - 1)] = 8'($urandom_range(0, 255));
      end else if (kind >= 94) begin
        seq_bytes.delete();
        seq_bytes.push_back(8'($urandom_range(0, 255)));
        keep = 1;
      end
      eos = ($urandom_range(0, 5) == 0);
      for (pos = 0; pos < keep; pos++) send_byte(seq_bytes[pos], eos && pos == keep - 1);
    end
    finish_phase();
  endtask

  // receiver holds off while the sender keeps offering bytes
  task automatic test_output_hold();
    hold_trigger++;
    test_random_text(40);
  endtask

  // no idling on either side
  task automatic test_full_rate();
    tx_gaps_on = 1'b0;
    rx_stall_on = 1'b0;
    test_random_text(80);
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_valid_forms();
    test_rejected_forms();
    test_truncation();
    test_output_hold();
    test_random_text(340);
    test_full_rate();
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/utf8d_pkg.sv
sv/utf8d_buf.sv
sv/utf8d_dec.sv
sv/utf8_stream_decoder.sv
verif/tb_utf8_stream_decoder.sv
